// ----- src/csvfs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csvfs_pkg
// Shared types and constants of the CSV field splitter.
// ----------------------------------------------------------------------------
package csvfs_pkg;

	localparam int BYTE_W = 8;
	localparam int MODE_W = 3;
	localparam int CFG_IDX_W = 2;

	localparam logic [MODE_W-1:0] MODE_ROW_START   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_FIELD_START = 3'd1;
	localparam logic [MODE_W-1:0] MODE_UNQUOTED    = 3'd2;
	localparam logic [MODE_W-1:0] MODE_QUOTED      = 3'd3;
	localparam logic [MODE_W-1:0] MODE_AFTER_CLOSE = 3'd4;

	localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;
	localparam logic [BYTE_W-1:0] ZERO_BYTE    = 8'h00;

	localparam logic [BYTE_W-1:0] DELIM_RESET  = 8'd44;
	localparam logic [BYTE_W-1:0] QUOTE_RESET  = 8'd34;
	localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'd92;

	localparam logic [CFG_IDX_W-1:0] CFG_DELIMITER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_QUOTE     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE    = 2'd2;

	typedef struct packed {
		logic [BYTE_W-1:0] delimiter_char;
		logic [BYTE_W-1:0] quote_char;
		logic [BYTE_W-1:0] escape_char;
	} cfg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] content_byte;
		logic              content_valid;
		logic              field_end;
		logic              row_end;
	} res_t;

endpackage
`default_nettype wire

// ----- src/csv_field_splitter_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csv_field_splitter_top
// Splits a CSV byte stream into field content, field ends and row ends.
//
// channel  dir  payload
// s_*      in   tdata[7:0] text byte, tuser[0] kind (1 = end of input)
// m_*      out  tdata[7:0] content byte, tuser[0] content valid,
//               tuser[1] field end, tlast row end
// cfg_*    in   index 0 delimiter, 1 quote, 2 escape; data[7:0]
//
// one request per cycle while the output is not stalled; a request passes
// through the input register and then the output register
// the mode register is updated as a request leaves the input register
// end of input at row start gives no result
// a stalled output fills the skid entry, then s_tready drops
// reset restores comma, double quote and backslash and clears the mode
// ----------------------------------------------------------------------------
module csv_field_splitter_top (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             s_tvalid,
	output logic                            s_tready,
	input  wire  [csvfs_pkg::BYTE_W-1:0]    s_tdata,  // text_byte
	input  wire                             s_tuser,  // kind
	output logic                            m_tvalid,
	input  wire                             m_tready,
	output logic [csvfs_pkg::BYTE_W-1:0]    m_tdata,  // content_byte
	output logic [1:0]                      m_tuser,  // content_valid, field_end
	output logic                            m_tlast,  // row_end
	input  wire                             cfg_valid,
	output logic                            cfg_ready,
	input  wire  [csvfs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire  [csvfs_pkg::BYTE_W-1:0]    cfg_data
);
	import csvfs_pkg::*;

	cfg_t cfg;
	logic res_valid;
	logic res_ready;
	res_t res;
	res_t out_res;

	csvfs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	csvfs_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_kind   (s_tuser),
		.in_byte   (s_tdata),
		.res_ready (res_ready),
		.res_valid (res_valid),
		.res       (res)
	);

	csvfs_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (res_valid),
		.in_ready  (res_ready),
		.in_res    (res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = out_res.content_byte;
	assign m_tuser = {out_res.field_end, out_res.content_valid};
	assign m_tlast = out_res.row_end;

endmodule
`default_nettype wire

// ----- src/csvfs_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csvfs_cfg
// Delimiter, quote and escape registers with their write port.
// ----------------------------------------------------------------------------
module csvfs_cfg (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_valid,
	output logic                            cfg_ready,
	input  wire  [csvfs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire  [csvfs_pkg::BYTE_W-1:0]    cfg_data,
	output csvfs_pkg::cfg_t                 cfg
);
	import csvfs_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delimiter_char <= DELIM_RESET;
			cfg_q.quote_char     <= QUOTE_RESET;
			cfg_q.escape_char    <= ESCAPE_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_DELIMITER: cfg_q.delimiter_char <= cfg_data;
				CFG_QUOTE:     cfg_q.quote_char     <= cfg_data;
				CFG_ESCAPE:    cfg_q.escape_char    <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- src/csvfs_parse.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csvfs_parse
// Input register and field/row decode with the parse mode register.
// ----------------------------------------------------------------------------
module csvfs_parse (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire  csvfs_pkg::cfg_t        cfg,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire                          in_kind,
	input  wire  [csvfs_pkg::BYTE_W-1:0] in_byte,
	input  wire                          res_ready,
	output logic                         res_valid,
	output csvfs_pkg::res_t              res
);
	import csvfs_pkg::*;

	logic              valid_s1;
	logic              kind_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic [MODE_W-1:0] mode_q;
	logic              esc_q;

	logic [MODE_W-1:0] mode_nxt;
	logic              esc_nxt;
	logic              has_res;
	logic              line_stop;
	logic              fire;
	res_t              res_c;

	assign fire      = valid_s1 && res_ready;
	assign in_ready  = !valid_s1 || res_ready;
	assign line_stop = (byte_s1 == NEWLINE_BYTE) || (byte_s1 == ZERO_BYTE);
	assign res_valid = valid_s1 && has_res;
	assign res       = res_c;

	always_comb begin
		mode_nxt = mode_q;
		esc_nxt  = esc_q;
		has_res  = 1'b1;
		res_c    = '0;
		if (kind_s1) begin
			mode_nxt = MODE_ROW_START;
			esc_nxt  = 1'b0;
			if (mode_q == MODE_UNQUOTED || mode_q == MODE_QUOTED ||
			    mode_q == MODE_AFTER_CLOSE || mode_q == MODE_FIELD_START) begin
				res_c.field_end = 1'b1;
				res_c.row_end   = 1'b1;
			end else begin
				has_res = 1'b0;
			end
		end else begin
			case (mode_q)
				MODE_UNQUOTED: begin
					if (byte_s1 == cfg.delimiter_char) begin
						res_c.field_end = 1'b1;
						mode_nxt        = MODE_FIELD_START;
					end else if (line_stop) begin
						res_c.field_end = 1'b1;
						res_c.row_end   = 1'b1;
						mode_nxt        = MODE_ROW_START;
					end else begin
						res_c.content_byte  = byte_s1;
						res_c.content_valid = 1'b1;
					end
				end
				MODE_QUOTED: begin
					if (byte_s1 == cfg.quote_char && !esc_q) begin
						mode_nxt = MODE_AFTER_CLOSE;
						esc_nxt  = 1'b0;
					end else if (byte_s1 == ZERO_BYTE) begin
						res_c.field_end = 1'b1;
						res_c.row_end   = 1'b1;
						mode_nxt        = MODE_ROW_START;
						esc_nxt         = 1'b0;
					end else if (byte_s1 == NEWLINE_BYTE) begin
						res_c.content_byte  = byte_s1;
						res_c.content_valid = 1'b1;
						res_c.field_end     = 1'b1;
						res_c.row_end       = 1'b1;
						mode_nxt            = MODE_ROW_START;
						esc_nxt             = 1'b0;
					end else begin
						res_c.content_byte  = byte_s1;
						res_c.content_valid = 1'b1;
						esc_nxt             = (byte_s1 == cfg.escape_char);
					end
				end
				MODE_AFTER_CLOSE: begin
					res_c.field_end = 1'b1;
					res_c.row_end   = line_stop;
					mode_nxt        = line_stop ? MODE_ROW_START : MODE_FIELD_START;
					esc_nxt         = 1'b0;
				end
				default: begin
					if (byte_s1 == cfg.quote_char) begin
						mode_nxt = MODE_QUOTED;
						esc_nxt  = 1'b0;
					end else if (byte_s1 == cfg.delimiter_char) begin
						res_c.field_end = 1'b1;
						mode_nxt        = MODE_FIELD_START;
					end else if (line_stop) begin
						res_c.field_end = 1'b1;
						res_c.row_end   = 1'b1;
						mode_nxt        = MODE_ROW_START;
					end else begin
						res_c.content_byte  = byte_s1;
						res_c.content_valid = 1'b1;
						mode_nxt            = MODE_UNQUOTED;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mode_q   <= MODE_ROW_START;
			esc_q    <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (fire) begin
				mode_q <= mode_nxt;
				esc_q  <= esc_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_s1 <= in_kind;
			byte_s1 <= in_byte;
		end
	end

endmodule
`default_nettype wire

// ----- src/csvfs_skid.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csvfs_skid
// Two-entry output register that keeps the result side off the parse path.
// ----------------------------------------------------------------------------
module csvfs_skid (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  wire csvfs_pkg::res_t in_res,
	output logic                 out_valid,
	input  wire                  out_ready,
	output csvfs_pkg::res_t      out_res
);
	import csvfs_pkg::*;

	logic main_valid_q;
	logic skid_valid_q;
	res_t main_q;
	res_t skid_q;

	assign in_ready  = !skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_res   = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_ready || !main_valid_q) begin
			if (skid_valid_q) begin
				main_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= in_valid;
			end
		end else if (in_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready || !main_valid_q) begin
			if (skid_valid_q)
				main_q <= skid_q;
			else if (in_valid)
				main_q <= in_res;
		end else if (in_valid && !skid_valid_q) begin
			skid_q <= in_res;
		end
	end

endmodule
`default_nettype wire
